// ===== hdl/scasc_pkg.sv =====
// ----------------------------------------------------------------------------
// Scancode set-1 to ASCII package
// Item codes, modifier scancodes, US key tables and item field layout.
// ----------------------------------------------------------------------------
package scasc_pkg;

   // Item kinds carried on req_tuser.
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam int SCAN_W      = 8;
   localparam int CHAR_W      = 7;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   // Result field positions inside rsp_tdata.
   localparam int RSP_CHAR_LSB   = 0;
   localparam int RSP_DROP_BIT   = 7;
   localparam int RSP_SHIFT_BIT  = 8;
   localparam int RSP_CTRL_BIT   = 9;
   localparam int RSP_ALT_BIT    = 10;

   // Modifier make and break codes.
   localparam logic [SCAN_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [SCAN_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [SCAN_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [SCAN_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [SCAN_W-1:0] SC_CTRL_MAKE    = 8'h1D;
   localparam logic [SCAN_W-1:0] SC_CTRL_BREAK   = 8'h9D;
   localparam logic [SCAN_W-1:0] SC_ALT_MAKE     = 8'h38;
   localparam logic [SCAN_W-1:0] SC_ALT_BREAK    = 8'hB8;
   localparam int                BREAK_BIT       = 7;

   localparam int MAP_LEN = 59;
   localparam int MAP_IDX_W = 6;

   localparam logic [CHAR_W-1:0] PLAIN_MAP [MAP_LEN] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00,
      7'h00, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
      7'h70, 7'h5B, 7'h5D, 7'h0A,
      7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
      7'h3B, 7'h27, 7'h60,
      7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
      7'h2E, 7'h2F, 7'h00,
      7'h2A, 7'h00, 7'h20, 7'h00
   };

   localparam logic [CHAR_W-1:0] UPPER_MAP [MAP_LEN] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00,
      7'h00, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
      7'h50, 7'h7B, 7'h7D, 7'h0A,
      7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C,
      7'h3A, 7'h22, 7'h7E,
      7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
      7'h3E, 7'h3F, 7'h00,
      7'h2A, 7'h00, 7'h20, 7'h00
   };

   // Maps a make code to its character; zero means the key yields nothing.
   function automatic logic [CHAR_W-1:0] map_char(input logic [SCAN_W-1:0] code,
                                                  input logic              upper);
      logic [MAP_IDX_W-1:0] idx;
      logic [CHAR_W-1:0]    ch;
      idx = code[MAP_IDX_W-1:0];
      ch  = '0;
      if (code < SCAN_W'(MAP_LEN)) begin
         ch = upper ? UPPER_MAP[idx] : PLAIN_MAP[idx];
      end
      return ch;
   endfunction

endpackage

// ===== hdl/scasc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scasc_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/scancode_set1_to_ascii_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// Scancode set-1 to ASCII FIFO unit
// Decodes US set-1 scancodes into characters, tracks shift, ctrl and alt,
// and buffers characters in a RAM-based ring buffer read by request items.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req_     in         tuser: op; tdata: scan_byte
//  rsp_     out        tuser: got_char; tdata: char_code, dropped, shift_held,
//                      ctrl_held, alt_held
//
// One item per cycle while rsp_tready stays high; a result passes through
// the read stage, whose RAM read is registered at the accepting edge, and
// then loads into the output register once that register is free.
// Synchronous reset clears the modifier flags, both pointers and the pipeline;
// the character RAM is not cleared, since only written entries are ever read.
// While rsp_tready is low the output register holds its item, one more item
// is taken into the read stage, and then req_tready drops.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_fifo_unit #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,   // [0] op
   input  logic [scasc_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [7:0] scan_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic                               rsp_tuser,   // [0] got_char
   // [6:0] char_code, [7] dropped, [8] shift_held, [9] ctrl_held,
   // [10] alt_held, [15:11] zero
   output logic [scasc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CW    = scasc_pkg::CHAR_W;

   // Architectural state.
   logic             shift_ff, shift_in;
   logic             ctrl_ff, ctrl_in;
   logic             alt_ff, alt_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;

   // Read stage, waiting on the RAM read data.
   logic s1_valid_ff, s1_valid_in;
   logic s1_pop_ff, s1_drop_ff, s1_shift_ff, s1_ctrl_ff, s1_alt_ff;

   // Output register.
   logic          out_valid_ff, out_valid_in;
   logic          out_got_ff;
   logic [CW-1:0] out_char_ff;
   logic          out_drop_ff, out_shift_ff, out_ctrl_ff, out_alt_ff;

   logic                              accept, out_free, out_load;
   logic                              is_read, is_mod, push, pop, drop;
   logic [scasc_pkg::SCAN_W-1:0]      code;
   logic [CW-1:0]                     ch;
   logic [PTR_W-1:0]                  wr_next, rd_next;
   logic [CW-1:0]                     ram_rd_data;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign out_load   = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   assign is_read = (req_tuser == scasc_pkg::OP_READ);
   assign code    = req_tdata[scasc_pkg::SCAN_W-1:0];
   assign wr_next = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      alt_in   = alt_ff;
      is_mod   = 1'b1;
      case (code)
         scasc_pkg::SC_LSHIFT_MAKE,
         scasc_pkg::SC_RSHIFT_MAKE:  shift_in = 1'b1;
         scasc_pkg::SC_LSHIFT_BREAK,
         scasc_pkg::SC_RSHIFT_BREAK: shift_in = 1'b0;
         scasc_pkg::SC_CTRL_MAKE:    ctrl_in  = 1'b1;
         scasc_pkg::SC_CTRL_BREAK:   ctrl_in  = 1'b0;
         scasc_pkg::SC_ALT_MAKE:     alt_in   = 1'b1;
         scasc_pkg::SC_ALT_BREAK:    alt_in   = 1'b0;
         default:                    is_mod   = 1'b0;
      endcase
      if (!accept || is_read) begin
         shift_in = shift_ff;
         ctrl_in  = ctrl_ff;
         alt_in   = alt_ff;
      end
   end

   // Break codes and codes past the table give no character.
   assign ch = code[scasc_pkg::BREAK_BIT] ? '0 : scasc_pkg::map_char(code, shift_ff);

   assign push = accept && !is_read && !is_mod && (ch != '0) && (wr_next != rd_ptr_ff);
   assign drop = accept && !is_read && !is_mod && (ch != '0) && (wr_next == rd_ptr_ff);
   assign pop  = accept && is_read && (wr_ptr_ff != rd_ptr_ff);

   assign wr_ptr_in = push ? wr_next : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_next : rd_ptr_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Pops only touch entries written in an earlier cycle, so a write and a
   // read of the same entry never meet in one cycle.
   scasc_ram #(
      .WIDTH (CW),
      .DEPTH (FIFO_DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (ch),
      .rd_en   (pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         alt_ff       <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         ctrl_ff      <= ctrl_in;
         alt_ff       <= alt_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pop_ff   <= pop;
         s1_drop_ff  <= drop;
         s1_shift_ff <= shift_in;
         s1_ctrl_ff  <= ctrl_in;
         s1_alt_ff   <= alt_in;
      end
      if (out_load) begin
         out_got_ff   <= s1_pop_ff;
         out_char_ff  <= s1_pop_ff ? ram_rd_data : '0;
         out_drop_ff  <= s1_drop_ff;
         out_shift_ff <= s1_shift_ff;
         out_ctrl_ff  <= s1_ctrl_ff;
         out_alt_ff   <= s1_alt_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_got_ff;
   assign rsp_tdata  = {5'b0, out_alt_ff, out_ctrl_ff, out_shift_ff, out_drop_ff, out_char_ff};

endmodule

// ===== hdl/scasc_checker.sv =====
// ----------------------------------------------------------------------------
// Scancode set-1 to ASCII port checker
// Watches the result channel of the unit and checks item consistency.
// ----------------------------------------------------------------------------
module scasc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic                              rsp_tuser,
   input logic [scasc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // A popped character is never zero, since only non-zero ones are stored.
   a_got_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser
      |-> rsp_tdata[scasc_pkg::CHAR_W-1:0] != '0)
      else $error("popped character is zero");

   a_nochar_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser
      |-> rsp_tdata[scasc_pkg::CHAR_W-1:0] == '0)
      else $error("character code without a pop");

   // A read item cannot also report a dropped character.
   a_drop_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[scasc_pkg::RSP_DROP_BIT]
      |-> !rsp_tuser)
      else $error("dropped and got_char both set");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready
      |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind scancode_set1_to_ascii_fifo_unit scasc_checker u_scasc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
